// ----- rtl/macroman_path_to_utf16_assert.svh -----
// Assertion macros shared by the path converter RTL.
`ifndef MACROMAN_PATH_TO_UTF16_ASSERT_SVH
`define MACROMAN_PATH_TO_UTF16_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define MR2U_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define MR2U_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MR2U_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define MR2U_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/mr2u_pkg.sv -----
// Shared types, constants and the byte classifier of the path converter.
`timescale 1ns / 1ps
package mr2u_pkg;

    localparam int MAX_UNITS = 3;

    // Completion status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NULL     = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Special source bytes
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] ESC_LEAD  = 8'hFC;

    localparam logic [15:0] CTRL_BASE   = 16'hF000;
    localparam logic [15:0] ERR_BYTES   = 16'hFFFF;
    localparam logic [15:0] BUF_DEFAULT = 16'hFFFE;

    // Position within the leading volume prefix
    typedef enum logic [1:0] {
        PH_START,
        PH_PREFIX,
        PH_BODY
    } t_phase;

    // Classification of one byte going through the single-byte mapping
    typedef struct packed {
        logic        is_null;
        logic        is_table;
        logic [15:0] lit;
    } t_class;

    // One queued group of results caused by one path byte
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [1:0]                 n_units;
        logic                       eop;
        logic [1:0]                 status;
        logic [15:0]                out_bytes;
    } t_qentry;

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c.is_null  = (b == 8'h00);
        c.is_table = 1'b0;
        c.lit      = {8'h00, b};
        case (b) inside
            [8'h01:8'h1F]: c.lit = CTRL_BASE | {8'h00, b};
            CH_DQUOTE:     c.lit = 16'hF020;
            CH_STAR:       c.lit = 16'hF021;
            CH_SLASH:      c.lit = 16'hF022;
            CH_LT:         c.lit = 16'hF023;
            CH_GT:         c.lit = 16'hF024;
            CH_QMARK:      c.lit = 16'hF025;
            CH_BSLASH:     c.lit = 16'hF026;
            CH_PIPE:       c.lit = 16'hF027;
            CH_COLON:      c.lit = {8'h00, CH_BSLASH};
            [8'h80:8'hFF]: c.is_table = 1'b1;
            default:       ;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/mr2u_if.sv -----
// Handshake interfaces for the input byte channel and the result channel.
`timescale 1ns / 1ps
interface mr2u_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [7:0]  byte_value;
    logic [6:0]  table_index;
    logic [15:0] table_value;
    logic        final_byte;

    modport source (output valid, mode, byte_value, table_index, table_value, final_byte,
                    input ready);
    modport sink   (input valid, mode, byte_value, table_index, table_value, final_byte,
                    output ready);
endinterface

interface mr2u_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] unit;
    logic        has_unit;
    logic        end_of_path;
    logic [1:0]  status;
    logic [15:0] out_bytes;

    modport source (output valid, unit, has_unit, end_of_path, status, out_bytes,
                    input ready);
    modport sink   (input valid, unit, has_unit, end_of_path, status, out_bytes,
                    output ready);
endinterface

// ----- rtl/mr2u_front.sv -----
// Front end: accepts words, tracks path state, classifies bytes, holds the table.
`timescale 1ns / 1ps
module mr2u_front import mr2u_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_wdata,
    mr2u_in_if.sink       i_in,
    output logic          o_push_valid,
    output t_qentry       o_push_entry,
    input  logic          i_push_ready
);

    // Configuration and path state
    logic [15:0] r_buffer_bytes;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_held0, n_held0;
    logic [7:0]  r_held1, n_held1;
    logic [1:0]  r_held_count, n_held_count;
    logic [15:0] r_pos;
    logic [1:0]  r_err;

    // High-byte table
    logic [15:0] r_table [128];
    logic [15:0] r_rd_a, r_rd_b;

    // Classified stage
    logic                       r_s1_valid;
    logic [MAX_UNITS-1:0][15:0] r_s1_lit;
    logic [1:0]                 r_s1_tab;
    logic [1:0]                 r_s1_n;
    logic                       r_s1_eop;
    logic [1:0]                 r_s1_status;
    logic [15:0]                r_s1_bytes;

    logic                       w_accept, w_path, w_last, w_body, w_esc;
    logic [7:0]                 w_b;
    logic [15:0]                w_limit, w_esc_unit;
    logic [1:0]                 w_cand_n;
    logic [MAX_UNITS-1:0][7:0]  w_cand;
    t_class                     w_cls [MAX_UNITS];
    logic [1:0]                 w_err_nx;
    logic [15:0]                w_pos_nx;
    logic [1:0]                 w_n_units;
    logic [MAX_UNITS-1:0][15:0] w_lit;
    logic [MAX_UNITS-1:0]       w_tab;

    assign w_b      = i_in.byte_value;
    assign w_last   = i_in.final_byte;
    assign i_in.ready = !r_s1_valid || i_push_ready;
    assign w_accept = i_in.valid && i_in.ready;
    assign w_path   = w_accept && i_in.mode;
    assign w_limit  = {r_buffer_bytes[15:1], 1'b0};

    // Hold the buffer size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_bytes <= BUF_DEFAULT;
        end else if (i_cfg_we) begin
            r_buffer_bytes <= i_cfg_wdata;
        end
    end

    // Advance the volume prefix phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_START: begin
                if (w_b == CH_COLON) n_phase = PH_PREFIX;
                else                 n_phase = PH_BODY;
            end
            PH_PREFIX: begin
                if (w_b == CH_COLON) n_phase = PH_BODY;
            end
            PH_BODY:  n_phase = PH_BODY;
            default:  n_phase = PH_START;
        endcase
    end

    // Decode whether this byte belongs to the path body
    always_comb begin
        w_body = (r_phase == PH_BODY) || ((r_phase == PH_START) && (w_b != CH_COLON));
    end

    // Gather escape bytes and choose the bytes to convert now
    always_comb begin
        w_cand_n     = 2'd0;
        w_cand       = '0;
        w_esc        = 1'b0;
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_held_count = r_held_count;
        w_esc_unit   = {r_held0[1:0], r_held1[6:0], w_b[6:0]};
        if (w_body) begin
            if (r_err != ST_OK) begin
                n_held_count = 2'd0;
            end else begin
                case (r_held_count)
                    2'd0: begin
                        if (w_b >= ESC_LEAD && !w_last) begin
                            n_held0      = w_b;
                            n_held_count = 2'd1;
                        end else begin
                            w_cand_n  = 2'd1;
                            w_cand[0] = w_b;
                        end
                    end
                    2'd1: begin
                        if (w_b[7] && !w_last) begin
                            n_held1      = w_b;
                            n_held_count = 2'd2;
                        end else begin
                            n_held_count = 2'd0;
                            w_cand_n     = 2'd2;
                            w_cand[0]    = r_held0;
                            w_cand[1]    = w_b;
                        end
                    end
                    default: begin
                        n_held_count = 2'd0;
                        if (w_b[7]) begin
                            w_esc    = 1'b1;
                            w_cand_n = 2'd1;
                        end else begin
                            w_cand_n = 2'd3;
                            w_cand   = {w_b, r_held1, r_held0};
                        end
                    end
                endcase
            end
        end
    end

    // Classify each chosen byte
    always_comb begin
        for (int k = 0; k < MAX_UNITS; k++) begin
            w_cls[k] = classify(w_cand[k]);
        end
    end

    // Emit units in order, stop at the first null byte or overflow
    always_comb begin
        w_err_nx  = r_err;
        w_pos_nx  = r_pos;
        w_n_units = 2'd0;
        w_lit     = '0;
        w_tab     = '0;
        for (int k = 0; k < MAX_UNITS; k++) begin
            if ((2'(k) < w_cand_n) && (w_err_nx == ST_OK)) begin
                if (!w_esc && w_cls[k].is_null) begin
                    w_err_nx = ST_NULL;
                end else if (w_pos_nx >= w_limit) begin
                    w_err_nx = ST_OVERFLOW;
                end else begin
                    w_lit[k]  = w_esc ? w_esc_unit : w_cls[k].lit;
                    w_tab[k]  = !w_esc && w_cls[k].is_table;
                    w_n_units = w_n_units + 2'd1;
                    w_pos_nx  = w_pos_nx + 16'd2;
                end
            end
        end
    end

    // Commit path state; drop it all at the end of a path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_held_count <= 2'd0;
            r_pos        <= 16'd0;
            r_err        <= ST_OK;
        end else if (w_path) begin
            if (w_last) begin
                r_phase      <= PH_START;
                r_held_count <= 2'd0;
                r_pos        <= 16'd0;
                r_err        <= ST_OK;
            end else begin
                r_phase      <= n_phase;
                r_held_count <= n_held_count;
                r_pos        <= w_pos_nx;
                r_err        <= w_err_nx;
            end
        end
    end

    // Hold escape lead bytes
    always_ff @(posedge i_clk) begin
        if (w_path) begin
            r_held0 <= n_held0;
            r_held1 <= n_held1;
        end
    end

    // Write table entries and read the two lookup ports
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_in.mode) begin
            r_table[i_in.table_index] <= i_in.table_value;
        end
        if (w_path) begin
            r_rd_a <= r_table[w_cand[0][6:0]];
            r_rd_b <= r_table[w_cand[1][6:0]];
        end
    end

    // Load the classified stage when it frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= w_path && (w_last || (w_n_units != 2'd0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && w_path) begin
            r_s1_lit    <= w_lit;
            r_s1_tab    <= w_tab[1:0];
            r_s1_n      <= w_n_units;
            r_s1_eop    <= w_last;
            r_s1_status <= w_last ? w_err_nx : ST_OK;
            r_s1_bytes  <= !w_last ? 16'd0 : ((w_err_nx != ST_OK) ? ERR_BYTES : w_pos_nx);
        end
    end

    // Merge table data into the queued word
    always_comb begin
        o_push_valid               = r_s1_valid;
        o_push_entry.units[0]      = r_s1_tab[0] ? r_rd_a : r_s1_lit[0];
        o_push_entry.units[1]      = r_s1_tab[1] ? r_rd_b : r_s1_lit[1];
        o_push_entry.units[2]      = r_s1_lit[2];
        o_push_entry.n_units       = r_s1_n;
        o_push_entry.eop           = r_s1_eop;
        o_push_entry.status        = r_s1_status;
        o_push_entry.out_bytes     = r_s1_bytes;
    end

endmodule

// ----- rtl/mr2u_fifo.sv -----
// Short queue of result groups between the front and back ends.
`timescale 1ns / 1ps
module mr2u_fifo import mr2u_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    output logic    o_push_ready,
    input  t_qentry i_push_entry,
    output logic    o_pop_valid,
    input  logic    i_pop_ready,
    output t_qentry o_pop_entry
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_qentry       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/mr2u_back.sv -----
// Back end: splits each queued group into single results behind an output register.
`timescale 1ns / 1ps
module mr2u_back import mr2u_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_pop_valid,
    output logic    o_pop_ready,
    input  t_qentry i_pop_entry,
    mr2u_out_if.source o_out
);

    logic [1:0]  r_slot;
    logic        r_out_valid;
    logic [15:0] r_unit;
    logic        r_has_unit;
    logic        r_eop;
    logic [1:0]  r_status;
    logic [15:0] r_out_bytes;

    logic [1:0]  w_res_n;
    logic        w_load, w_issue, w_group_end;

    assign w_res_n     = (i_pop_entry.n_units == 2'd0) ? 2'd1 : i_pop_entry.n_units;
    assign w_group_end = (r_slot == w_res_n - 2'd1);
    assign w_load      = !r_out_valid || o_out.ready;
    assign w_issue     = i_pop_valid && w_load;
    assign o_pop_ready = w_load && w_group_end;

    // Step through the results of the head group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_slot <= w_group_end ? 2'd0 : r_slot + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= i_pop_valid;
            end
        end
    end

    // Load the output register; end fields only on the last result of a path
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_unit      <= i_pop_entry.units[r_slot];
            r_has_unit  <= (i_pop_entry.n_units != 2'd0);
            r_eop       <= i_pop_entry.eop && w_group_end;
            r_status    <= (i_pop_entry.eop && w_group_end) ? i_pop_entry.status : ST_OK;
            r_out_bytes <= (i_pop_entry.eop && w_group_end) ? i_pop_entry.out_bytes : 16'd0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.unit        = r_unit;
    assign o_out.has_unit    = r_has_unit;
    assign o_out.end_of_path = r_eop;
    assign o_out.status      = r_status;
    assign o_out.out_bytes   = r_out_bytes;

endmodule

// ----- rtl/macroman_path_to_utf16.sv -----
// Top level of the path byte to UTF-16 converter.
`timescale 1ns / 1ps
// Converts path bytes to UTF-16 units, one input word per clock: a table
// write or a path byte is taken every cycle while the internal queue has room.
// A path byte gives up to three results and the output delivers one result per
// cycle while the sink is ready, so a byte that flushes held escape bytes
// occupies the output for two or three results; the QUEUE_DEPTH-entry queue
// between the classifier and the output stage absorbs such bursts. The first
// result of a byte passes the classified stage with the table read, then the
// queue, then the output register. The 128-entry table is read through two
// registered ports in the cycle the byte is taken.
`include "macroman_path_to_utf16_assert.svh"
module macroman_path_to_utf16 import mr2u_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    mr2u_in_if.sink     i_in,
    mr2u_out_if.source  o_out
);

    logic    w_push_valid, w_push_ready, w_pop_valid, w_pop_ready;
    t_qentry w_push_entry, w_pop_entry;

    // Accept and classify
    mr2u_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_entry (w_push_entry),
        .i_push_ready (w_push_ready)
    );

    // Decouple the two sides
    mr2u_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_entry  (w_pop_entry)
    );

    // Serialise results
    mr2u_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_entry (w_pop_entry),
        .o_out       (o_out)
    );

    // Every final byte leaves a result group in the classified stage
    `MR2U_ASSERT_NXT(a_final_gives_result, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.mode && i_in.final_byte, w_push_valid, "final byte left no result")
    // A bare marker only closes a path
    `MR2U_ASSERT_IMP(a_bare_is_end, i_clk, i_rst_n, o_out.valid && !o_out.has_unit, o_out.end_of_path, "bare result not at end of path")
    // Mid-path results carry no status
    `MR2U_ASSERT_IMP(a_mid_clean, i_clk, i_rst_n, o_out.valid && !o_out.end_of_path, (o_out.status == ST_OK) && (o_out.out_bytes == 16'd0), "status on mid-path result")
    // An error reports the all-ones length
    `MR2U_ASSERT_IMP(a_err_len, i_clk, i_rst_n, o_out.valid && o_out.end_of_path && (o_out.status != ST_OK), o_out.out_bytes == ERR_BYTES, "error without all-ones length")

endmodule

// ----- dv/macroman_path_to_utf16_tb.sv -----
// Self-checking testbench for the path byte to UTF-16 converter.
`timescale 1ns / 1ps
module macroman_path_to_utf16_tb;
    import mr2u_pkg::*;

    localparam logic MODE_TABLE = 1'b0;
    localparam logic MODE_PATH  = 1'b1;

    // One input word as offered on the byte channel
    typedef struct packed {
        logic        mode;
        logic [7:0]  byte_value;
        logic [6:0]  table_index;
        logic [15:0] table_value;
        logic        final_byte;
    } t_path_word;

    // One result word as seen on the output channel
    typedef struct packed {
        logic [15:0] unit;
        logic        has_unit;
        logic        end_of_path;
        logic [1:0]  status;
        logic [15:0] out_bytes;
    } t_unit_result;

    typedef logic [7:0] t_byte_q [$];

    // Predicts the UTF-16 results of each accepted word and checks them in order
    class t_unit_scoreboard;
        logic [15:0]  buffer_size;
        logic [15:0]  high_units [128];
        logic [7:0]   held [2];
        int           held_count;
        t_phase       prefix_state;
        logic [15:0]  out_pos;
        logic [1:0]   err_code;
        logic [15:0]  step_units [$];
        t_unit_result expected_units [$];
        int           fail_count;

        function new();
            buffer_size = BUF_DEFAULT;
            foreach (high_units[i]) high_units[i] = '0;
            fail_count = 0;
            restart_path();
        endfunction

        function void restart_path();
            held[0]      = '0;
            held[1]      = '0;
            held_count   = 0;
            prefix_state = PH_START;
            out_pos      = '0;
            err_code     = ST_OK;
        endfunction

        // Emit one unit unless an error is latched or the buffer is full
        function void put_unit(logic [15:0] u);
            if (err_code != ST_OK) return;
            if (out_pos >= {buffer_size[15:1], 1'b0}) begin
                err_code = ST_OVERFLOW;
                return;
            end
            step_units.push_back(u);
            out_pos = out_pos + 16'd2;
        endfunction

        // Single-byte mapping: nulls, controls, SMB-illegal characters, table
        function void map_byte(logic [7:0] b);
            logic [15:0] u;
            if (err_code != ST_OK) return;
            if (b == 8'h00) begin
                err_code = ST_NULL;
                return;
            end
            if (b < 8'h20) begin
                u = CTRL_BASE | {8'h00, b};
            end else begin
                case (b)
                    CH_DQUOTE: u = 16'hF020;
                    CH_STAR:   u = 16'hF021;
                    CH_SLASH:  u = 16'hF022;
                    CH_LT:     u = 16'hF023;
                    CH_GT:     u = 16'hF024;
                    CH_QMARK:  u = 16'hF025;
                    CH_BSLASH: u = 16'hF026;
                    CH_PIPE:   u = 16'hF027;
                    CH_COLON:  u = {8'h00, CH_BSLASH};
                    default:   u = b[7] ? high_units[b[6:0]] : {8'h00, b};
                endcase
            end
            put_unit(u);
        endfunction

        // Body byte: collect three-byte escapes, otherwise map directly
        function void body_byte(logic [7:0] b, logic last);
            if (err_code != ST_OK) begin
                held_count = 0;
                return;
            end
            if (held_count == 0) begin
                if (b >= ESC_LEAD && !last) begin
                    held[0]    = b;
                    held_count = 1;
                end else begin
                    map_byte(b);
                end
            end else if (held_count == 1) begin
                if (b[7] && !last) begin
                    held[1]    = b;
                    held_count = 2;
                end else begin
                    held_count = 0;
                    map_byte(held[0]);
                    map_byte(b);
                end
            end else begin
                held_count = 0;
                if (b[7]) begin
                    put_unit({held[0][1:0], held[1][6:0], b[6:0]});
                end else begin
                    map_byte(held[0]);
                    map_byte(held[1]);
                    map_byte(b);
                end
            end
        endfunction

        // Note an accepted word and queue the results it causes
        function void note_word(t_path_word w);
            t_unit_result r;
            if (w.mode == MODE_TABLE) begin
                high_units[w.table_index] = w.table_value;
                return;
            end
            step_units.delete();
            if (prefix_state == PH_START) begin
                if (w.byte_value == CH_COLON) begin
                    prefix_state = PH_PREFIX;
                end else begin
                    prefix_state = PH_BODY;
                    body_byte(w.byte_value, w.final_byte);
                end
            end else if (prefix_state == PH_PREFIX) begin
                if (w.byte_value == CH_COLON) prefix_state = PH_BODY;
            end else begin
                body_byte(w.byte_value, w.final_byte);
            end
            foreach (step_units[i]) begin
                r             = '0;
                r.unit        = step_units[i];
                r.has_unit    = 1'b1;
                expected_units.push_back(r);
            end
            if (w.final_byte) begin
                // A path end with no unit gives a bare end marker
                if (step_units.size() == 0) expected_units.push_back('0);
                r             = expected_units.pop_back();
                r.end_of_path = 1'b1;
                r.status      = err_code;
                r.out_bytes   = (err_code != ST_OK) ? ERR_BYTES : out_pos;
                expected_units.push_back(r);
                restart_path();
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, actual %h", name, want, got);
                fail_count++;
            end
        endfunction

        // Check one result word against the oldest expectation
        function void check_result(t_unit_result got);
            t_unit_result want;
            if (expected_units.size() == 0) begin
                $error("unexpected result word: unit %h has_unit %b end %b status %0d",
                       got.unit, got.has_unit, got.end_of_path, got.status);
                fail_count++;
                return;
            end
            want = expected_units.pop_front();
            compare_field("unit", want.unit, got.unit);
            compare_field("has_unit", 16'(want.has_unit), 16'(got.has_unit));
            compare_field("end_of_path", 16'(want.end_of_path), 16'(got.end_of_path));
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("out_bytes", want.out_bytes, got.out_bytes);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    mr2u_in_if   in_ch ();
    mr2u_out_if  out_ch ();

    t_unit_scoreboard sb = new();
    int          words_sent;
    logic        idle_on;
    logic        hold_req;
    logic [15:0] buf_plan [8];

    macroman_path_to_utf16 u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #2000000;
        $display("macroman_path_to_utf16 regression: fail");
        $finish;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input t_path_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       = 1'b1;
        in_ch.mode        = w.mode;
        in_ch.byte_value  = w.byte_value;
        in_ch.table_index = w.table_index;
        in_ch.table_value = w.table_value;
        in_ch.final_byte  = w.final_byte;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_table(input logic [6:0] idx, input logic [15:0] val);
        t_path_word w;
        w.mode        = MODE_TABLE;
        w.byte_value  = 8'($urandom);
        w.table_index = idx;
        w.table_value = val;
        w.final_byte  = 1'($urandom);
        send_word(w);
    endtask

    task automatic send_path(input t_byte_q q, input bit mix_table);
        t_path_word w;
        foreach (q[i]) begin
            // Slip in a table write now and then, mid-path
            if (mix_table && $urandom_range(0, 19) == 0)
                send_table(7'($urandom), 16'($urandom));
            w.mode        = MODE_PATH;
            w.byte_value  = q[i];
            w.table_index = 7'($urandom);
            w.table_value = 16'($urandom);
            w.final_byte  = (i == q.size() - 1);
            send_word(w);
        end
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain(input int settle);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.expected_units.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.buffer_size = v;
    endtask

    function automatic logic [7:0] special_byte();
        case ($urandom_range(0, 8))
            0:       return CH_DQUOTE;
            1:       return CH_STAR;
            2:       return CH_SLASH;
            3:       return CH_LT;
            4:       return CH_GT;
            5:       return CH_QMARK;
            6:       return CH_BSLASH;
            7:       return CH_PIPE;
            default: return CH_COLON;
        endcase
    endfunction

    // Random path: optional volume prefix, then a mix of byte classes
    function automatic t_byte_q random_path();
        t_byte_q    q;
        int         len;
        int         r;
        int         start;
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) begin
            q.push_back(CH_COLON);
            repeat ($urandom_range(0, 3)) begin
                b = 8'($urandom);
                q.push_back(b == CH_COLON ? 8'h00 : b);
            end
            if ($urandom_range(0, 4) != 0) q.push_back(CH_COLON);
        end
        start = q.size();
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        while (q.size() - start < len) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (r < 45) begin
                q.push_back(special_byte());
            end else if (r < 52) begin
                q.push_back(8'($urandom_range(8'h01, 8'h1F)));
            end else if (r < 66) begin
                q.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end else if (r < 82) begin
                // Well-formed escape
                q.push_back(8'($urandom_range(ESC_LEAD, 8'hFF)));
                q.push_back(8'h80 | 8'($urandom_range(0, 127)));
                q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end else if (r < 88) begin
                // Escape broken by a low byte
                q.push_back(8'($urandom_range(ESC_LEAD, 8'hFF)));
                if ($urandom_range(0, 1) == 1)
                    q.push_back(8'h80 | 8'($urandom_range(0, 127)));
                q.push_back(8'($urandom_range(1, 127)));
            end else if (r < 91) begin
                q.push_back(8'h00);
            end else begin
                q.push_back(8'($urandom));
            end
        end
        return q;
    endfunction

    // Result sink: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        int r;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = 150;
            end
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (!idle_on) begin
                out_ch.ready = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_ch.ready = 1'b1;
                end else begin
                    out_ch.ready = 1'b0;
                    if (r >= 96) stall_left = $urandom_range(8, 30);
                end
            end
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        t_unit_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.unit        = out_ch.unit;
            got.has_unit    = out_ch.has_unit;
            got.end_of_path = out_ch.end_of_path;
            got.status      = out_ch.status;
            got.out_bytes   = out_ch.out_bytes;
            sb.check_result(got);
        end
    end

    // Main sequence
    initial begin
        int phase_start;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_TABLE;
        in_ch.byte_value  = '0;
        in_ch.table_index = '0;
        in_ch.table_value = '0;
        in_ch.final_byte  = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        idle_on           = 1'b1;
        hold_req          = 1'b0;
        words_sent        = 0;
        buf_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'd6, 16'd11, 16'd40, 16'd17, BUF_DEFAULT};
        buf_plan[6] = 16'($urandom_range(2, 64));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Load every table entry so no high byte reads an unwritten one
        for (int i = 0; i < 128; i++)
            send_table(7'(i), (i == 0) ? 16'h0000 : (i == 127) ? 16'hFFFF : 16'($urandom));

        // Directed paths at the reset buffer size
        send_path('{CH_COLON, 8'h76, CH_COLON, 8'h01, CH_DQUOTE, CH_STAR, CH_SLASH, CH_LT,
                    CH_GT, CH_QMARK, CH_BSLASH, CH_PIPE, CH_COLON, 8'h1F}, 1'b0);
        send_path('{8'h80, ESC_LEAD, 8'h81, 8'hFF, 8'hFD, 8'h41, 8'hFE, 8'h90}, 1'b0);
        send_path('{CH_COLON, 8'h00, 8'h78}, 1'b0);
        send_path('{8'h61, 8'h00, 8'h62}, 1'b0);
        send_path('{8'hFF, 8'h85, 8'h7A}, 1'b0);
        drain(8);
        write_buffer_size(16'd4);
        send_path('{8'h61, 8'h62, 8'h63}, 1'b0);

        // Random paths over a series of buffer sizes
        for (int p = 0; p < 8; p++) begin
            drain(8);
            write_buffer_size(buf_plan[p]);
            idle_on = (p != 2);
            if (p == 4) hold_req = 1'b1;
            phase_start = words_sent;
            while (words_sent - phase_start < 20) send_path(random_path(), 1'b1);
        end

        drain(20);
        if (sb.fail_count == 0) begin
            $display("macroman_path_to_utf16 regression: pass");
        end else begin
            $display("macroman_path_to_utf16 regression: fail");
        end
        $finish;
    end

endmodule
